// ===== design/wtol_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtol_pkg: shared types and constants of the wavetable oscillator
// Transaction structs, opcode and register codes, controller commands.
// ----------------------------------------------------------------------------
package wtol_pkg;

	localparam int FREQ_W       = 22;
	localparam int SPH_W        = 28;
	localparam int LEN_REG_W    = 13;
	localparam int IDX_IN_W     = 12;
	localparam int SAMPLE_W     = 16;
	localparam int PRODUCT_FRAC = 36;
	localparam int PROD_W       = FREQ_W + SPH_W;

	localparam logic [0:0] OP_SAMPLE = 1'b0;
	localparam logic [0:0] OP_WRITE  = 1'b1;

	localparam logic [0:0] REG_TABLE_LENGTH = 1'b0;
	localparam logic [0:0] REG_STEP_PER_HZ  = 1'b1;

	localparam logic [LEN_REG_W-1:0] TABLE_LENGTH_RST = 13'd4096;
	localparam logic [SPH_W-1:0]     STEP_PER_HZ_RST  = 28'd34359738;

	typedef struct packed {
		logic [0:0]                 opcode;
		logic [FREQ_W-1:0]          frequency;
		logic [IDX_IN_W-1:0]        table_index;
		logic signed [SAMPLE_W-1:0] table_value;
		logic                       last_in_block;
	} req_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       block_end;
	} rsp_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_MOD,
		ST_READ,
		ST_INTERP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic write_entry;
		logic load_sample;
		logic step;
		logic reduce;
		logic read;
		logic interp;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic k_zero;
		logic out_free;
	} status_t;

endpackage

// ===== design/wtol_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtol_ram: generic RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module wtol_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== design/wtol_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtol_ctrl: oscillator sequencer
// Accepts request transactions and steps the datapath through one sample.
// ----------------------------------------------------------------------------
module wtol_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_is_write,
	output logic             req_stall,
	input  wtol_pkg::status_t st,
	output wtol_pkg::cmd_t    cmd
);
	import wtol_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_is_write) begin
						cmd.write_entry = 1'b1;
					end else begin
						cmd.load_sample = 1'b1;
						state_d         = ST_STEP;
					end
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = ST_MOD;
			end
			ST_MOD: begin
				cmd.reduce = 1'b1;
				if (st.k_zero) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_INTERP;
			end
			ST_INTERP: begin
				cmd.interp = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.write_entry, cmd.load_sample, cmd.step, cmd.reduce,
			cmd.read, cmd.interp, cmd.finish}))
		else $error("more than one datapath command");

	a_load_then_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_sample |=> cmd.step)
		else $error("sample load not followed by step");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> st.out_free)
		else $error("finish issued while output register busy");

endmodule

// ===== design/wtol_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtol_datapath: phase accumulator, wrap unit and interpolator
// Step multiply, saturation, shift-subtract wrap, table read, lerp, output.
// ----------------------------------------------------------------------------
module wtol_datapath #(
	parameter int TABLE_DEPTH     = 4096,
	parameter int PHASE_FRAC_BITS = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wtol_pkg::cmd_t                   cmd,
	output wtol_pkg::status_t                st,
	input  wtol_pkg::req_item_t              req,
	input  logic [wtol_pkg::LEN_REG_W-1:0]   table_length,
	input  logic [wtol_pkg::SPH_W-1:0]       step_per_hz,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output wtol_pkg::rsp_item_t              rsp
);
	import wtol_pkg::*;

	localparam int F       = PHASE_FRAC_BITS;
	localparam int AW      = $clog2(TABLE_DEPTH);
	localparam int LEN_W   = $clog2(TABLE_DEPTH + 1);
	localparam int LIMIT_W = LEN_W + F;
	localparam int PHASE_W = AW + F;
	localparam int SUM_W   = PHASE_W + 1;
	localparam int WIDE_W  = LIMIT_W + AW + 1;
	localparam int KW      = (AW > 1) ? $clog2(AW) : 1;
	localparam int KMAX    = AW - 1;
	localparam int SHIFT   = PRODUCT_FRAC - F;
	localparam int IPW     = F + SAMPLE_W + 2;
	localparam int DW      = IPW - F;

	localparam logic signed [IPW-1:0] HALF = {{(IPW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

	// length clamp and wrap limit
	logic [31:0]        tl_ext;
	logic [31:0]        len_ext;
	logic [LEN_W-1:0]   len;
	logic [LIMIT_W-1:0] limit;

	always_comb begin
		tl_ext = 32'(table_length);
		if (tl_ext < 32'd2) begin
			len_ext = 32'd2;
		end else if (tl_ext > 32'(TABLE_DEPTH)) begin
			len_ext = 32'(TABLE_DEPTH);
		end else begin
			len_ext = tl_ext;
		end
		len   = LEN_W'(len_ext);
		limit = {len, {F{1'b0}}};
	end

	// table write
	logic [31:0] widx_ext;
	logic        wr_en;

	assign widx_ext = 32'(req.table_index);
	assign wr_en    = cmd.write_entry && (widx_ext < 32'(TABLE_DEPTH));

	// phase state
	logic [PROD_W-1:0]  prod_q;
	logic               last_q;
	logic [PHASE_W-1:0] phase_q;
	logic [SUM_W-1:0]   rem_q;
	logic [KW-1:0]      k_q;
	logic [F-1:0]       frac_q;
	logic signed [IPW-1:0] lerp_q;

	logic [PROD_W-1:0]  step_full;
	logic [PHASE_W-1:0] step_sat;
	logic [SUM_W-1:0]   sum;
	logic [WIDE_W-1:0]  sum_w;
	logic [WIDE_W-1:0]  rem_w;
	logic [WIDE_W-1:0]  lim_sh;

	always_comb begin
		step_full = prod_q >> SHIFT;
		if (step_full >= PROD_W'(limit)) begin
			step_sat = PHASE_W'(limit - LIMIT_W'(1));
		end else begin
			step_sat = PHASE_W'(step_full);
		end
		sum    = SUM_W'(phase_q) + SUM_W'(step_sat);
		sum_w  = WIDE_W'(sum);
		rem_w  = WIDE_W'(rem_q);
		lim_sh = WIDE_W'(limit) << k_q;
	end

	assign st.k_zero = (k_q == '0);

	// table addresses from the reduced phase
	logic [AW-1:0]    lower;
	logic [LEN_W-1:0] up_ext;
	logic [AW-1:0]    upper;

	always_comb begin
		lower  = rem_q[F +: AW];
		up_ext = LEN_W'(lower) + LEN_W'(1);
		if (up_ext >= len) begin
			upper = '0;
		end else begin
			upper = AW'(up_ext);
		end
	end

	logic [SAMPLE_W-1:0] rd_lo;
	logic [SAMPLE_W-1:0] rd_hi;

	wtol_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.we     (wr_en),
		.waddr  (widx_ext[AW-1:0]),
		.wdata  (req.table_value),
		.raddr_a(lower),
		.raddr_b(upper),
		.rdata_a(rd_lo),
		.rdata_b(rd_hi)
	);

	// interpolation
	logic signed [SAMPLE_W:0]   diff;
	logic signed [IPW-1:0]      lerp_prod;
	logic signed [IPW-1:0]      rnd;
	logic signed [DW-1:0]       delta;
	logic signed [DW-1:0]       smp_full;

	always_comb begin
		diff      = signed'({rd_hi[SAMPLE_W-1], rd_hi}) - signed'({rd_lo[SAMPLE_W-1], rd_lo});
		lerp_prod = IPW'(signed'({1'b0, frac_q}) * diff);
		rnd       = lerp_q + HALF;
		delta     = signed'(rnd[IPW-1:F]);
		smp_full  = signed'(DW'(signed'(rd_lo))) + delta;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			prod_q <= PROD_W'(req.frequency) * PROD_W'(step_per_hz);
			last_q <= req.last_in_block;
		end
		if (cmd.step) begin
			rem_q <= sum;
			k_q   <= (sum_w >= (WIDE_W'(limit) << 1)) ? KW'(KMAX) : '0;
		end else if (cmd.reduce) begin
			if (rem_w >= lim_sh) begin
				rem_q <= SUM_W'(rem_w - lim_sh);
			end
			if (k_q != '0) begin
				k_q <= k_q - KW'(1);
			end
		end
		if (cmd.read) begin
			frac_q <= rem_q[F-1:0];
		end
		if (cmd.interp) begin
			lerp_q <= lerp_prod;
		end
		if (cmd.finish) begin
			rsp.sample    <= smp_full[SAMPLE_W-1:0];
			rsp.block_end <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (cmd.read) begin
				phase_q <= rem_q[PHASE_W-1:0];
			end
			if (cmd.finish) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	assign st.out_free = !rsp_valid || !rsp_stall;

	a_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read |-> (rem_w < WIDE_W'(limit)))
		else $error("phase not below table length after wrap");

	a_k_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.reduce && !st.k_zero) |=> (k_q == $past(k_q) - KW'(1)))
		else $error("wrap shift count did not step down");

	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp_valid)
		else $error("finished sample not presented");

endmodule

// ===== design/wavetable_oscillator_lerp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_oscillator_lerp_top: wavetable oscillator with linear interpolation
// Request channel: a write transaction stores one table entry; a sample
// transaction advances the phase by frequency * step_per_hz and returns one
// interpolated sample on the response channel, with block_end copied.
// Write transactions give no response and leave the sequencer in idle.
// A sample reaches the response register through these steps in the
// normal case: step multiply at acceptance, add and wrap test, one
// shift-subtract step, table read, interpolation multiply, output. After
// table_length was lowered the wrap unit repeats the shift-subtract step
// for limit shifts from log2(TABLE_DEPTH)-1 down to zero. The next request
// is accepted once the sequencer is back in idle, after the prior output.
// The response register decouples the sides: a stalled response holds, the
// next request is still accepted and its sample waits in the final step.
// Reset clears the phase and the response valid and sets table_length to
// 4096 and step_per_hz to 34359738; table contents are undefined until
// written. Registers are to be written over APB only while idle (unchecked).
// ----------------------------------------------------------------------------
module wavetable_oscillator_lerp_top #(
	parameter int TABLE_DEPTH     = 4096,
	parameter int PHASE_FRAC_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  wtol_pkg::req_item_t req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output wtol_pkg::rsp_item_t rsp_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import wtol_pkg::*;

	logic [LEN_REG_W-1:0] table_length_q;
	logic [SPH_W-1:0]     step_per_hz_q;
	logic [0:0]           reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= TABLE_LENGTH_RST;
			step_per_hz_q  <= STEP_PER_HZ_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_TABLE_LENGTH: table_length_q <= pwdata[LEN_REG_W-1:0];
				REG_STEP_PER_HZ:  step_per_hz_q  <= pwdata[SPH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TABLE_LENGTH: prdata = 32'(table_length_q);
			REG_STEP_PER_HZ:  prdata = 32'(step_per_hz_q);
			default:          prdata = '0;
		endcase
	end

	cmd_t    cmd;
	status_t st;

	wtol_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_is_write(req_data.opcode == OP_WRITE),
		.req_stall   (req_stall),
		.st          (st),
		.cmd         (cmd)
	);

	wtol_datapath #(
		.TABLE_DEPTH    (TABLE_DEPTH),
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.req         (req_data),
		.table_length(table_length_q),
		.step_per_hz (step_per_hz_q),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp_data)
	);

endmodule
